>>> hdl/bchd_pkg.sv
// shared types and codes for the button click and hold detector
package bchd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 10;
    localparam int THR_W      = 16;
    localparam int KEY_W      = 3;

    localparam logic [TICK_W-1:0] TICK_RESET     = 10'd10;
    localparam logic [THR_W-1:0]  HOLD_THR_RESET = 16'd500;
    localparam logic [THR_W-1:0]  GAP_THR_RESET  = 16'd250;

    // item kind codes
    typedef enum logic {
        ITEM_SAMPLE = 1'b0,
        ITEM_CLEAR  = 1'b1
    } item_kind_t;

    // click kind codes
    typedef enum logic [1:0] {
        CLICK_NONE   = 2'd0,
        CLICK_SINGLE = 2'd1,
        CLICK_DOUBLE = 2'd2
    } click_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK     = 2'd0,
        REG_HOLD_THR = 2'd1,
        REG_GAP_THR  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [THR_W-1:0]  hold_thr_ms;
        logic [THR_W-1:0]  gap_threshold_ms;
    } cfg_t;

    // sticky per-key flags as stored
    typedef struct packed {
        logic       pressed;
        logic       hold;
        logic       dbl;
        logic       up;
        logic       idle;
        logic [1:0] click_kind;
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key_index;
        logic             pin_level;
    } sample_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic             pressed_flag;
        logic             hold_flag;
        logic             double_flag;
        logic             up_flag;
        logic             idle_flag;
        logic [1:0]       click_kind;
    } result_t;

endpackage

>>> hdl/bchd_ram.sv
// generic single-port-write ram with registered read
module bchd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/bchd_update.sv
// per-key state update: edge classing, timers, pending click and flags
module bchd_update
    import bchd_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic                 kind,
    input  logic                 pin_level,
    input  cfg_t                 cfg,
    input  logic                 cur_last,
    input  logic [TIME_BITS-1:0] cur_hold,
    input  logic [TIME_BITS-1:0] cur_gap,
    input  logic                 cur_pending,
    input  flags_t               cur_flags,
    output logic                 nxt_last,
    output logic [TIME_BITS-1:0] nxt_hold,
    output logic [TIME_BITS-1:0] nxt_gap,
    output logic                 nxt_pending,
    output flags_t               nxt_flags
);

    localparam int SW = ((TIME_BITS > TICK_W) ? TIME_BITS : TICK_W) + 1;
    localparam int CW = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

    logic [SW-1:0]        hold_sum;
    logic [SW-1:0]        gap_sum;
    logic [TIME_BITS-1:0] hold_sat;
    logic [TIME_BITS-1:0] gap_sat;

    // saturating timer adds
    assign hold_sum = SW'(cur_hold) + SW'(cfg.tick_ms);
    assign gap_sum  = SW'(cur_gap) + SW'(cfg.tick_ms);
    assign hold_sat = (|hold_sum[SW-1:TIME_BITS]) ? '1 : hold_sum[TIME_BITS-1:0];
    assign gap_sat  = (|gap_sum[SW-1:TIME_BITS]) ? '1 : gap_sum[TIME_BITS-1:0];

    always_comb
    begin
        nxt_last    = cur_last;
        nxt_hold    = cur_hold;
        nxt_gap     = cur_gap;
        nxt_pending = cur_pending;
        nxt_flags   = cur_flags;
        if (kind == ITEM_CLEAR)
        begin
            nxt_flags = '0;
        end
        else
        begin
            nxt_last = pin_level;
            if (cur_last && !pin_level)
            begin
                // down edge
                nxt_flags.pressed = 1'b1;
                nxt_hold          = '0;
                if (!cur_pending)
                begin
                    nxt_flags.click_kind = CLICK_SINGLE;
                    nxt_pending          = 1'b1;
                end
                else if (CW'(cur_gap) <= CW'(cfg.gap_threshold_ms))
                begin
                    nxt_flags.dbl        = 1'b1;
                    nxt_flags.click_kind = CLICK_DOUBLE;
                    nxt_pending          = 1'b0;
                end
            end
            else if (!cur_last && pin_level)
            begin
                // up edge
                nxt_flags.up = 1'b1;
                if (cur_pending)
                begin
                    nxt_gap = '0;
                end
            end
            else if (!pin_level)
            begin
                // held low
                nxt_hold = hold_sat;
                if (CW'(hold_sat) >= CW'(cfg.hold_thr_ms))
                begin
                    nxt_flags.hold = 1'b1;
                    nxt_pending    = 1'b0;
                end
            end
            else
            begin
                // idle high
                nxt_flags.idle = 1'b1;
                if (cur_pending)
                begin
                    if (CW'(gap_sat) > CW'(cfg.gap_threshold_ms))
                    begin
                        nxt_pending = 1'b0;
                        nxt_gap     = '0;
                    end
                    else
                    begin
                        nxt_gap = gap_sat;
                    end
                end
            end
        end
    end

endmodule

>>> hdl/button_click_hold_detector.sv
// top level: per-key gesture detector over a state ram with read-modify-write
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------
//  sample   | sample_valid / sample_stall  | sample_t: kind, key_index, pin
//  result   | result_valid / result_stall  | result_t: key, five flags, click
//  config   | cfg_we (no wait)             | cfg_index, cfg_data
//
// one item per cycle sustained while result_stall is low; an accepted item
// enters the update stage as the state ram read is issued on the accepting
// edge, and its update lands in the output register when that stage advances
// back-to-back items on the same key are served by forwarding the last write
// reset restores the register defaults; per-key valid flops make every entry
// read as released, zero timers and no flags, with no clearing pass
// a held result keeps the update stage full, and sample_stall rises only
// while both the update stage and the output register are occupied
module button_click_hold_detector
    import bchd_pkg::*;
#(
    parameter int NUM_KEYS  = 8,
    parameter int TIME_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    // entry layout: last level, hold time, gap time, pending, flags
    localparam int EW = 2 * TIME_BITS + 2 + FLAGS_W;
    localparam logic [EW-1:0] RESET_ENTRY = {1'b1, {(EW-1){1'b0}}};

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms          <= TICK_RESET;
            cfg_reg.hold_thr_ms      <= HOLD_THR_RESET;
            cfg_reg.gap_threshold_ms <= GAP_THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICK:     cfg_reg.tick_ms          <= cfg_data[TICK_W-1:0];
                REG_HOLD_THR: cfg_reg.hold_thr_ms      <= cfg_data[THR_W-1:0];
                REG_GAP_THR:  cfg_reg.gap_threshold_ms <= cfg_data[THR_W-1:0];
                default:      ;
            endcase
        end
    end

    // handshake and stage control
    logic accept;
    logic s1_adv;
    logic s1_fire;
    logic s1_valid_reg;
    logic res_valid_reg;

    assign s1_adv       = !res_valid_reg || !result_stall;
    assign sample_stall = s1_valid_reg && !s1_adv;
    assign accept       = sample_valid && !sample_stall;
    assign s1_fire      = s1_valid_reg && s1_adv;
    assign result_valid = res_valid_reg;

    logic [AW-1:0] rd_addr;
    logic          rd_in_range;

    assign rd_addr     = AW'(sample.key_index);
    assign rd_in_range = (32'(sample.key_index) < NUM_KEYS);

    // update stage: item waits here for the ram read data
    sample_t       s1_item_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_in_range_reg;
    logic          s1_vbit_reg;

    logic [NUM_KEYS-1:0] vbit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg     <= sample;
            s1_addr_reg     <= rd_addr;
            s1_in_range_reg <= rd_in_range;
            s1_vbit_reg     <= rd_in_range && vbit_reg[rd_addr];
        end
    end

    // state ram
    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] ram_q;

    bchd_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // entry valid bits; an entry never written reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbit_reg <= '0;
        end
        else if (wr_en)
        begin
            vbit_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // forwarding of the most recent write, covers a read issued on the write edge
    logic          byp_valid_reg;
    logic [AW-1:0] byp_addr_reg;
    logic [EW-1:0] byp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= wr_data;
        end
    end

    logic [EW-1:0] cur_entry;

    always_comb
    begin
        if (byp_valid_reg && (byp_addr_reg == s1_addr_reg))
        begin
            cur_entry = byp_data_reg;
        end
        else if (s1_vbit_reg)
        begin
            cur_entry = ram_q;
        end
        else
        begin
            cur_entry = RESET_ENTRY;
        end
    end

    // unpack current entry
    logic                 cur_last;
    logic [TIME_BITS-1:0] cur_hold;
    logic [TIME_BITS-1:0] cur_gap;
    logic                 cur_pending;
    flags_t               cur_flags;

    assign {cur_last, cur_hold, cur_gap, cur_pending, cur_flags} = cur_entry;

    logic                 nxt_last;
    logic [TIME_BITS-1:0] nxt_hold;
    logic [TIME_BITS-1:0] nxt_gap;
    logic                 nxt_pending;
    flags_t               nxt_flags;

    bchd_update #(
        .TIME_BITS (TIME_BITS)
    ) u_update (
        .kind        (s1_item_reg.kind),
        .pin_level   (s1_item_reg.pin_level),
        .cfg         (cfg_reg),
        .cur_last    (cur_last),
        .cur_hold    (cur_hold),
        .cur_gap     (cur_gap),
        .cur_pending (cur_pending),
        .cur_flags   (cur_flags),
        .nxt_last    (nxt_last),
        .nxt_hold    (nxt_hold),
        .nxt_gap     (nxt_gap),
        .nxt_pending (nxt_pending),
        .nxt_flags   (nxt_flags)
    );

    // out-of-range keys leave the state alone
    assign wr_en   = s1_fire && s1_in_range_reg;
    assign wr_data = {nxt_last, nxt_hold, nxt_gap, nxt_pending, nxt_flags};

    // output register
    result_t res_next;

    always_comb
    begin
        res_next.key_out = s1_item_reg.key_index;
        if (s1_in_range_reg)
        begin
            res_next.pressed_flag = nxt_flags.pressed;
            res_next.hold_flag    = nxt_flags.hold;
            res_next.double_flag  = nxt_flags.dbl;
            res_next.up_flag      = nxt_flags.up;
            res_next.idle_flag    = nxt_flags.idle;
            res_next.click_kind   = nxt_flags.click_kind;
        end
        else
        begin
            res_next.pressed_flag = 1'b0;
            res_next.hold_flag    = 1'b0;
            res_next.double_flag  = 1'b0;
            res_next.up_flag      = 1'b0;
            res_next.idle_flag    = 1'b0;
            res_next.click_kind   = CLICK_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result <= res_next;
        end
    end

endmodule

>>> hdl/bchd_checker.sv
// port-level checks for the detector, bound to the top level
module bchd_checker
    import bchd_pkg::*;
#(
    parameter int NUM_KEYS = 8
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("held result changed");

    // keys beyond the table carry no flags
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (32'(result.key_out) >= NUM_KEYS) |->
            !result.pressed_flag && !result.hold_flag && !result.double_flag &&
            !result.up_flag && !result.idle_flag && (result.click_kind == CLICK_NONE))
        else $error("out-of-range key shows flags");

    // a click of any kind comes only with a press
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.double_flag || (result.click_kind != CLICK_NONE)) |->
            result.pressed_flag)
        else $error("click without press");

    // double flag and click kind agree on a double click
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.click_kind == CLICK_DOUBLE) |-> result.double_flag)
        else $error("double click kind without double flag");

    // nothing comes out right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !result_valid)
        else $error("result right after reset");

endmodule

bind button_click_hold_detector bchd_checker #(.NUM_KEYS(NUM_KEYS)) u_bchd_checker (.*);
